@@ sv/fxa_pkg.sv @@
package fxa_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 8;
    localparam int INT_W     = WORD_W - FRAC_W;
    localparam int FLOAT_W   = 32;
    localparam int DIV_STEPS = WORD_W + FRAC_W;
    // Cycles from the accepting edge to the edge that takes the result.
    localparam int LATENCY   = DIV_STEPS + 3;

    typedef enum logic [3:0] {
        ACT_FROM_INT   = 4'd0,
        ACT_FROM_FLOAT = 4'd1,
        ACT_TO_INT     = 4'd2,
        ACT_TO_FLOAT   = 4'd3,
        ACT_ADD        = 4'd4,
        ACT_SUB        = 4'd5,
        ACT_MUL        = 4'd6,
        ACT_DIV        = 4'd7,
        ACT_COMPARE    = 4'd8,
        ACT_MIN        = 4'd9,
        ACT_MAX        = 4'd10,
        ACT_INC        = 4'd11
    } action_t;

    typedef struct packed {
        logic [3:0]               action;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
        logic signed [INT_W-1:0]  int_value;
        logic [FLOAT_W-1:0]       float_bits;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] fixed_result;
        logic signed [INT_W-1:0]  int_result;
        logic [FLOAT_W-1:0]       float_result;
        logic                     is_equal;
        logic                     is_less;
        logic                     is_greater;
        logic                     error_flag;
    } result_t;

    // Command plus operand magnitudes, carried alongside the divider chain.
    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] mag_a;
        logic [WORD_W-1:0] mag_b;
        logic              neg_a;
        logic              neg_b;
    } beat_t;

    // Running state of the shift-subtract division held by each cell.
    typedef struct packed {
        logic [WORD_W-1:0]    rem;
        logic [DIV_STEPS-1:0] nq;
    } div_state_t;

    // Applies a sign to a magnitude and clamps to the word range.
    // Returns {error, word}.
    function automatic logic [WORD_W:0] saturate(input logic neg, input logic ovf,
                                                 input logic [63:0] mag);
        logic [63:0] half;
        logic [WORD_W:0] res;
        half = 64'd1 << (WORD_W - 1);
        if (neg) begin
            if (ovf || mag > half)
                res = {1'b1, half[WORD_W-1:0]};
            else
                res = {1'b0, WORD_W'(64'd0 - mag)};
        end
        else begin
            if (ovf || mag > half - 64'd1)
                res = {1'b1, WORD_W'(half - 64'd1)};
            else
                res = {1'b0, mag[WORD_W-1:0]};
        end
        return res;
    endfunction

endpackage

@@ sv/fxa_div_cell.sv @@
module fxa_div_cell
    import fxa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vld,
    input  beat_t      beat,
    input  div_state_t state,
    output logic       vld_out,
    output beat_t      beat_out,
    output div_state_t state_out
);

    logic       vld_reg;
    beat_t      beat_reg;
    div_state_t state_reg;
    div_state_t state_next;
    logic [WORD_W:0] trial;

    // One restoring step: bring in the next numerator bit, try the divisor.
    always_comb
    begin
        trial = {state.rem, state.nq[DIV_STEPS-1]};
        state_next.nq = {state.nq[DIV_STEPS-2:0], 1'b0};
        if (trial >= {1'b0, beat.mag_b})
        begin
            state_next.rem   = WORD_W'(trial - {1'b0, beat.mag_b});
            state_next.nq[0] = 1'b1;
        end
        else
        begin
            state_next.rem = trial[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg  <= beat;
        state_reg <= state_next;
    end

    assign vld_out   = vld_reg;
    assign beat_out  = beat_reg;
    assign state_out = state_reg;

endmodule

@@ sv/fxa_post.sv @@
module fxa_post
    import fxa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vld,
    input  beat_t      beat,
    input  div_state_t state,
    output logic       done,
    output result_t    result
);

    // First stage registers.
    logic                     p1_vld_reg;
    logic [3:0]               p1_act_reg;
    logic                     p1_neg_reg;
    logic                     p1_na_reg;
    logic [WORD_W-1:0]        p1_fixed_reg;
    logic [INT_W-1:0]         p1_ival_reg;
    logic [2:0]               p1_cmp_reg;
    logic [2*WORD_W-1:0]      p1_prod_reg;
    logic [DIV_STEPS:0]       p1_quo_reg;
    logic                     p1_div0_reg;
    logic [WORD_W:0]          p1_ff_mag_reg;
    logic                     p1_ff_ovf_reg;
    logic                     p1_ff_neg_reg;
    logic [WORD_W-1:0]        p1_tf_norm_reg;
    logic [4:0]               p1_tf_p_reg;
    logic                     p1_tf_zero_reg;

    logic                     p2_vld_reg;
    result_t                  p2_res_reg;

    // First stage logic.
    logic [WORD_W-1:0]        fixed_next;
    logic [INT_W-1:0]         ival_next;
    logic [2:0]               cmp_next;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic [INT_W:0]           ti_mag;
    logic [7:0]               ff_e;
    logic [7:0]               ff_ee;
    logic [7:0]               ff_sh;
    logic [23:0]              ff_sig;
    logic [25:0]              ff_tmp;
    logic [WORD_W:0]          ff_mag_next;
    logic                     ff_ovf_next;
    logic                     ff_neg_next;
    logic [WORD_W-1:0]        tf_x;
    logic [4:0]               tf_cnt;
    logic                     round_up;

    always_comb
    begin
        a = beat.cmd.operand_a;
        b = beat.cmd.operand_b;
        fixed_next = '0;
        ival_next  = '0;
        cmp_next   = '0;
        ti_mag     = '0;
        case (beat.cmd.action)
            ACT_FROM_INT: fixed_next = {beat.cmd.int_value, {FRAC_W{1'b0}}};
            ACT_TO_INT:
            begin
                ti_mag    = (INT_W + 1)'({1'b0, beat.mag_a} >> FRAC_W);
                ival_next = beat.neg_a ? INT_W'(~ti_mag + 1'b1) : ti_mag[INT_W-1:0];
            end
            ACT_ADD:      fixed_next = WORD_W'(a + b);
            ACT_SUB:      fixed_next = WORD_W'(a - b);
            ACT_COMPARE:  cmp_next = {a == b, a < b, a > b};
            ACT_MIN:      fixed_next = (a < b) ? a : b;
            ACT_MAX:      fixed_next = (b < a) ? a : b;
            ACT_INC:      fixed_next = WORD_W'(a + 1);
            default:      fixed_next = '0;
        endcase

        // Float to fixed: align the significand, rounding half away from zero.
        ff_e        = beat.cmd.float_bits[30:23];
        ff_neg_next = beat.cmd.float_bits[31];
        ff_ovf_next = 1'b0;
        ff_mag_next = '0;
        ff_sig      = (ff_e == 8'd0) ? {1'b0, beat.cmd.float_bits[22:0]}
                                     : {1'b1, beat.cmd.float_bits[22:0]};
        ff_ee       = (ff_e == 8'd0) ? 8'd1 : ff_e;
        ff_sh       = '0;
        ff_tmp      = '0;
        if (ff_e == 8'd255)
        begin
            ff_ovf_next = 1'b1;
            if (beat.cmd.float_bits[22:0] != 23'd0)
                ff_neg_next = 1'b0;
        end
        else if (ff_ee >= 8'd142)
        begin
            ff_sh = ff_ee - 8'd142;
            if (ff_sh > 8'd8)
                ff_ovf_next = 1'b1;
            else
                ff_mag_next = (WORD_W + 1)'({9'd0, ff_sig} << ff_sh[3:0]);
        end
        else
        begin
            ff_sh = 8'd142 - ff_ee;
            if (ff_sh <= 8'd25)
            begin
                ff_tmp      = {2'b00, ff_sig} + (26'd1 << (ff_sh[4:0] - 5'd1));
                ff_mag_next = (WORD_W + 1)'(ff_tmp >> ff_sh[4:0]);
            end
        end

        // Fixed to float: leading zero count in five halving steps.
        tf_x   = beat.mag_a;
        tf_cnt = '0;
        for (int j = 4; j >= 0; j--)
        begin
            if ((tf_x >> (WORD_W - (1 << j))) == '0)
            begin
                tf_x   = tf_x << (1 << j);
                tf_cnt = tf_cnt | 5'(1 << j);
            end
        end

        // Division rounds up when twice the remainder reaches the divisor.
        round_up = {state.rem, 1'b0} >= {1'b0, beat.mag_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= vld;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_act_reg     <= beat.cmd.action;
        p1_neg_reg     <= beat.neg_a ^ beat.neg_b;
        p1_na_reg      <= beat.neg_a;
        p1_fixed_reg   <= fixed_next;
        p1_ival_reg    <= ival_next;
        p1_cmp_reg     <= cmp_next;
        p1_prod_reg    <= beat.mag_a * beat.mag_b;
        p1_quo_reg     <= {1'b0, state.nq} + (DIV_STEPS + 1)'(round_up);
        p1_div0_reg    <= (beat.mag_b == '0);
        p1_ff_mag_reg  <= ff_mag_next;
        p1_ff_ovf_reg  <= ff_ovf_next;
        p1_ff_neg_reg  <= ff_neg_next;
        p1_tf_norm_reg <= tf_x;
        p1_tf_p_reg    <= 5'd31 - tf_cnt;
        p1_tf_zero_reg <= (beat.mag_a == '0);
    end

    // Second stage: rounding and saturation into the output register.
    logic [2*WORD_W:0] mul_rnd;
    logic [WORD_W:0]   sat_w;
    logic [24:0]       tf_sig;
    logic [7:0]        tf_rem;
    logic              tf_up;
    logic [7:0]        tf_exp;
    result_t           res_next;

    always_comb
    begin
        res_next = '0;
        sat_w    = '0;
        mul_rnd  = {1'b0, p1_prod_reg} + (2 * WORD_W + 1)'(1 << (FRAC_W - 1));
        tf_rem   = p1_tf_norm_reg[7:0];
        tf_up    = (tf_rem > 8'h80) || (tf_rem == 8'h80 && p1_tf_norm_reg[8]);
        tf_sig   = {1'b0, p1_tf_norm_reg[31:8]} + 25'(tf_up);
        tf_exp   = {3'b000, p1_tf_p_reg} + 8'd119 + 8'(tf_sig[24]);
        case (p1_act_reg)
            ACT_FROM_FLOAT:
            begin
                sat_w = saturate(p1_ff_neg_reg, p1_ff_ovf_reg, 64'(p1_ff_mag_reg));
                res_next.fixed_result = sat_w[WORD_W-1:0];
                res_next.error_flag   = sat_w[WORD_W];
            end
            ACT_TO_INT: res_next.int_result = p1_ival_reg;
            ACT_TO_FLOAT:
            begin
                if (!p1_tf_zero_reg)
                    res_next.float_result = {p1_na_reg, tf_exp,
                        tf_sig[24] ? tf_sig[23:1] : tf_sig[22:0]};
            end
            ACT_MUL:
            begin
                sat_w = saturate(p1_neg_reg, 1'b0, 64'(mul_rnd >> FRAC_W));
                res_next.fixed_result = sat_w[WORD_W-1:0];
                res_next.error_flag   = sat_w[WORD_W];
            end
            ACT_DIV:
            begin
                if (p1_div0_reg)
                    sat_w = saturate(p1_na_reg, 1'b1, 64'd0);
                else
                    sat_w = saturate(p1_neg_reg, 1'b0, 64'(p1_quo_reg));
                res_next.fixed_result = sat_w[WORD_W-1:0];
                res_next.error_flag   = sat_w[WORD_W];
            end
            ACT_COMPARE:
            begin
                res_next.is_equal   = p1_cmp_reg[2];
                res_next.is_less    = p1_cmp_reg[1];
                res_next.is_greater = p1_cmp_reg[0];
            end
            default: res_next.fixed_result = p1_fixed_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p2_res_reg <= res_next;
    end

    assign done   = p2_vld_reg;
    assign result = p2_res_reg;

endmodule

@@ sv/fixed_point_alu_q24_8_core.sv @@
// Q24.8 fixed-point unit. A command beat is taken at every rising edge where
// start is high and busy is low; busy is high only during reset and the cycle
// after it, so a new beat can enter on every clock. Each beat gives exactly
// one result beat, shown for one cycle with done high, after it has passed
// one input register, a 40-cell restoring divider chain (one quotient bit
// per cell for 32 integer-plus-8 fraction bits) and two finishing stages
// for rounding and saturation. Every action takes that same path, so results
// leave in command order. The receiver cannot stall the unit; it must take
// every result beat in the cycle it appears.
module fixed_point_alu_q24_8_core
    import fxa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    logic  busy_reg;
    logic  s0_vld_reg;
    beat_t s0_beat_reg;
    beat_t s0_beat_next;

    // Magnitudes and signs are formed once here and shared by the
    // multiplier, the divider and the conversions downstream.
    always_comb
    begin
        s0_beat_next.cmd   = cmd;
        s0_beat_next.neg_a = cmd.operand_a[WORD_W-1];
        s0_beat_next.neg_b = cmd.operand_b[WORD_W-1];
        s0_beat_next.mag_a = cmd.operand_a[WORD_W-1] ? WORD_W'(-cmd.operand_a)
                                                     : cmd.operand_a;
        s0_beat_next.mag_b = cmd.operand_b[WORD_W-1] ? WORD_W'(-cmd.operand_b)
                                                     : cmd.operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= 1'b0;
            s0_vld_reg <= start && !busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_beat_reg <= s0_beat_next;
    end

    assign busy = busy_reg;

    // Divider chain. Cell k holds the partial remainder after k+1 quotient
    // bits; the numerator is the dividend magnitude shifted up by the
    // fraction width, and quotient bits shift in from the bottom.
    logic       vld_c   [DIV_STEPS+1];
    beat_t      beat_c  [DIV_STEPS+1];
    div_state_t state_c [DIV_STEPS+1];

    assign vld_c[0]      = s0_vld_reg;
    assign beat_c[0]     = s0_beat_reg;
    assign state_c[0].rem = '0;
    assign state_c[0].nq  = {s0_beat_reg.mag_a, {FRAC_W{1'b0}}};

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_cell
        fxa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .vld       (vld_c[k]),
            .beat      (beat_c[k]),
            .state     (state_c[k]),
            .vld_out   (vld_c[k+1]),
            .beat_out  (beat_c[k+1]),
            .state_out (state_c[k+1])
        );
    end

    // Multiply, conversions, simple arithmetic, final rounding and clamping.
    fxa_post u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld    (vld_c[DIV_STEPS]),
        .beat   (beat_c[DIV_STEPS]),
        .state  (state_c[DIV_STEPS]),
        .done   (done),
        .result (result)
    );

endmodule

@@ sv/fxa_checker.sv @@
module fxa_checker
    import fxa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input cmd_t    cmd,
    input logic    done,
    input result_t result
);

    logic [WORD_W-1:0] max_word;
    logic [WORD_W-1:0] min_word;

    assign max_word = {1'b0, {(WORD_W-1){1'b1}}};
    assign min_word = {1'b1, {(WORD_W-1){1'b0}}};

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a command");

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised outside reset");

    a_cmp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $countones({result.is_equal, result.is_less, result.is_greater}) <= 1)
        else $error("compare flags conflict");

    a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error_flag) |->
            (result.fixed_result == max_word || result.fixed_result == min_word))
        else $error("error without saturated result");

endmodule

bind fixed_point_alu_q24_8_core fxa_checker u_fxa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

@@ tb/sv/fixed_point_alu_q24_8_core_tb.sv @@
`timescale 1ns / 100ps

module fixed_point_alu_q24_8_core_tb;
    import fxa_pkg::*;

    // The unit takes a command beat on every rising edge where start is high
    // and busy is low, and returns exactly one result beat for each, flagged
    // by done. Results come back in command order, so a single FIFO of
    // predicted results is enough to check them.

    localparam int QUIET_LIMIT = 4000;   // cycles with no beat in either direction

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    cmd_t    cmd_backlog[$];     // commands waiting to be driven
    result_t predicted_q[$];     // predicted results, oldest first
    logic    cmd_taken;          // the command on the bus was accepted at the last edge
    int      idle_pct;           // chance in a hundred that the driver idles a cycle
    int      mismatch_count;
    int      quiet_cycles;

    fixed_point_alu_q24_8_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Signs a magnitude and clamps it to the word range, flagging overflow.
    function automatic logic [31:0] clamp_word(input logic neg, input logic [127:0] mag,
                                               output logic err);
        err = 1'b0;
        if (neg)
        begin
            if (mag > 128'h8000_0000)
            begin
                err = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(128'd0 - mag);
        end
        if (mag > 128'h7FFF_FFFF)
        begin
            err = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function automatic logic [31:0] float_to_fixed(input logic [31:0] bits,
                                                   output logic err);
        logic          neg;
        int            expo;
        int            shift;
        logic [127:0]  sig;
        logic [127:0]  mag;
        neg  = bits[31];
        expo = int'(bits[30:23]);
        sig  = 128'(bits[22:0]);
        if (expo == 255)
        begin
            // Infinity saturates by sign; NaN always goes to the top.
            if (sig != 0)
                neg = 1'b0;
            return clamp_word(neg, 128'd1 << 64, err);
        end
        if (expo == 0)
            expo = 1;
        else
            sig[23] = 1'b1;
        shift = expo - 150 + FRAC_W;
        if (shift > 40)
            return clamp_word(neg, 128'd1 << 64, err);
        if (shift >= 0)
            mag = sig << shift;
        else if (-shift > 25)
            mag = 128'd0;
        else
            mag = (sig + (128'd1 << (-shift - 1))) >> (-shift);
        return clamp_word(neg, mag, err);
    endfunction

    // Round to nearest even on the way to single precision.
    function automatic logic [31:0] fixed_to_float(input logic [63:0] a);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sig;
        logic [63:0] rem;
        logic [63:0] hlf;
        int          p;
        int          rs;
        neg = a[63];
        mag = neg ? 64'd0 - a : a;
        if (mag == 0)
            return 32'd0;
        p = 63;
        while (!mag[p])
            p--;
        if (p <= 23)
            sig = mag << (23 - p);
        else
        begin
            rs  = p - 23;
            rem = mag & ((64'd1 << rs) - 64'd1);
            hlf = 64'd1 << (rs - 1);
            sig = mag >> rs;
            if (rem > hlf || (rem == hlf && sig[0]))
                sig++;
            if (sig == (64'd1 << 24))
            begin
                sig = sig >> 1;
                p++;
            end
        end
        return {neg, 8'(p + 127 - FRAC_W), sig[22:0]};
    endfunction

    function automatic result_t predict_q24_8(input cmd_t c);
        result_t      r;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         err;
        r   = '0;
        err = 1'b0;
        a   = {{32{c.operand_a[31]}}, c.operand_a};
        b   = {{32{c.operand_b[31]}}, c.operand_b};
        ma  = a[63] ? 64'd0 - a : a;
        mb  = b[63] ? 64'd0 - b : b;
        case (c.action)
            ACT_FROM_INT:   r.fixed_result = {c.int_value, 8'd0};
            ACT_FROM_FLOAT: r.fixed_result = float_to_fixed(c.float_bits, err);
            ACT_TO_INT:     r.int_result = a[63] ? 24'(64'd0 - (ma >> FRAC_W))
                                                 : 24'(ma >> FRAC_W);
            ACT_TO_FLOAT:   r.float_result = fixed_to_float(a);
            ACT_ADD:        r.fixed_result = 32'(a + b);
            ACT_SUB:        r.fixed_result = 32'(a - b);
            ACT_MUL:
            begin
                prod = (128'(ma) * 128'(mb) + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
                r.fixed_result = clamp_word(a[63] ^ b[63], prod, err);
            end
            ACT_DIV:
            begin
                if (mb == 0)
                    r.fixed_result = clamp_word(a[63], 128'd1 << 64, err);
                else
                begin
                    num = 128'(ma) << FRAC_W;
                    quo = num / 128'(mb);
                    rem = num % 128'(mb);
                    // Round half away from zero on the magnitude.
                    if (rem >= 128'(mb) - rem)
                        quo++;
                    r.fixed_result = clamp_word(a[63] ^ b[63], quo, err);
                end
            end
            ACT_COMPARE:
            begin
                r.is_equal   = (a == b);
                r.is_less    = ($signed(a) < $signed(b));
                r.is_greater = ($signed(a) > $signed(b));
            end
            ACT_MIN:        r.fixed_result = ($signed(a) < $signed(b)) ? a[31:0] : b[31:0];
            ACT_MAX:        r.fixed_result = ($signed(b) < $signed(a)) ? a[31:0] : b[31:0];
            ACT_INC:        r.fixed_result = 32'(a + 64'd1);
            default:        r = '0;
        endcase
        r.error_flag = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents commands at the falling edge, holds each one until
    // the unit takes it, and idles at random between beats.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!start || cmd_taken))
        begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cmd   <= cmd_backlog.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, records an accepted command beat and
    // checks a result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        cmd_taken <= start && !busy;
        if (start && !busy)
            predicted_q.push_back(predict_q24_8(cmd));
        if (rst_n && done)
        begin
            if (predicted_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: fixed %h int %h float %h flags %b%b%b%b",
                             result.fixed_result, result.int_result, result.float_result,
                             result.is_equal, result.is_less, result.is_greater,
                             result.error_flag);
            end
            else
            begin
                want = predicted_q.pop_front();
                if (result.fixed_result !== want.fixed_result ||
                    result.int_result   !== want.int_result   ||
                    result.float_result !== want.float_result ||
                    result.is_equal     !== want.is_equal     ||
                    result.is_less      !== want.is_less      ||
                    result.is_greater   !== want.is_greater   ||
                    result.error_flag   !== want.error_flag)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result mismatch at %0t:", $realtime);
                        $display("  fixed %h/%h int %h/%h float %h/%h (expected/actual)",
                                 want.fixed_result, result.fixed_result,
                                 want.int_result, result.int_result,
                                 want.float_result, result.float_result);
                        $display("  eq %b/%b lt %b/%b gt %b/%b err %b/%b",
                                 want.is_equal, result.is_equal,
                                 want.is_less, result.is_less,
                                 want.is_greater, result.is_greater,
                                 want.error_flag, result.error_flag);
                    end
                end
            end
        end
    end

    // Watchdog: a long stretch with no beat in either direction means a hang.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("fixed_point_alu_q24_8_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic cmd_t make_cmd(input action_t act, input logic [31:0] a,
                                      input logic [31:0] b, input logic [23:0] iv,
                                      input logic [31:0] fb);
        cmd_t c;
        c.action     = act;
        c.operand_a  = a;
        c.operand_b  = b;
        c.int_value  = iv;
        c.float_bits = fb;
        return c;
    endfunction

    // Operands mix full-range words, small values near zero, the corner
    // words, and mid-size values so that multiply and divide both saturate
    // and stay in range often.
    function automatic logic [31:0] pick_operand();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = $urandom;
            1: w = 32'($urandom_range(8191)) - 32'd4096;
            2:
            begin
                case ($urandom_range(4))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'd0;
                    3: w = 32'd1;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end
            default: w = $signed($urandom) >>> $urandom_range(31);
        endcase
        return w;
    endfunction

    // Floats mostly land near the representable range, with some fully
    // random patterns to hit specials and subnormals.
    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        f = $urandom;
        if ($urandom_range(3) != 0)
            f[30:23] = 8'($urandom_range(105, 160));
        return f;
    endfunction

    function automatic cmd_t random_cmd();
        action_t act;
        if ($urandom_range(99) < 3)
            act = action_t'($urandom_range(15, 12));
        else
            act = action_t'($urandom_range(11));
        return make_cmd(act, pick_operand(), pick_operand(), 24'($urandom),
                        pick_float());
    endfunction

    task automatic wait_until_drained();
        while (cmd_backlog.size() != 0 || start || predicted_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_pct[4];
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        cmd_taken      = 1'b0;
        idle_pct       = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        // The receiver cannot stall, so two of the phases run the sender flat out.
        phase_pct      = '{0, 53, 0, 32};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: field extremes, every action and each special case.
        cmd_backlog.push_back(make_cmd(ACT_FROM_INT, 0, 0, 24'h80_0000, 0));
        cmd_backlog.push_back(make_cmd(ACT_FROM_INT, 0, 0, 24'h7F_FFFF, 0));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'h3F80_0000));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'hBFC0_0000));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'h7F80_0000));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'hFF80_0000));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'hFFC0_0001));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'hCF80_0000));
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'h0000_0001));
        // Exactly half a raw unit rounds away from zero.
        cmd_backlog.push_back(make_cmd(ACT_FROM_FLOAT, 0, 0, 0, 32'hBB00_0000));
        cmd_backlog.push_back(make_cmd(ACT_TO_INT, 32'hFFFF_FFFF, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_TO_INT, 32'h8000_0000, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_TO_FLOAT, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_TO_FLOAT, 32'h7FFF_FFFF, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_TO_FLOAT, 32'h8000_0000, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_ADD, 32'h7FFF_FFFF, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_SUB, 32'h8000_0000, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_MUL, 32'hFFFF_FF80, 32'h0000_0001, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_DIV, 32'h0000_0100, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_DIV, 32'hFFFF_FF00, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_DIV, 32'h8000_0000, 32'h0000_0001, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_COMPARE, 32'h8000_0000, 32'h8000_0000, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_COMPARE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_MIN, 32'hFFFF_FFFF, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_MAX, 32'hFFFF_FFFF, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_INC, 32'h7FFF_FFFF, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(action_t'(4'd15), 32'h1234_5678, 7, 24'h1, 32'h1));

        // Random beats over several idling phases. The pipeline is drained
        // before each phase change, so the sender also pauses with nothing
        // outstanding.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_until_drained();
            idle_pct = phase_pct[ph];
            for (int i = 0; i < 500; i++)
                cmd_backlog.push_back(random_cmd());
        end

        wait_until_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0 && predicted_q.size() == 0)
            $display("fixed_point_alu_q24_8_core verification clean");
        else
            $display("fixed_point_alu_q24_8_core verification failed");
        $finish;
    end

endmodule
